@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HTI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/hti_pkg.sv @@
// Shared constants, types and saturation helpers of the height-field interpolator
package hti_pkg;

  localparam int GRID_SIDE   = 256;
  localparam int HEIGHT_BITS = 16;
  localparam int IDX_W       = $clog2(GRID_SIDE);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int DEPTH       = GRID_SIDE * GRID_SIDE;

  localparam int DIM_W       = 9;
  localparam int GAIN_W      = 16;
  localparam int CELL_W      = 8;
  localparam int PIX_W       = 8;
  localparam int POS_W       = 18;
  localparam int FRAC_W      = 8;
  localparam int FRAC_ONE    = 1 << FRAC_W;
  localparam int OUT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int ACT_W       = 2;

  localparam int CMP_W       = 11;
  localparam int WGT_W       = 11;
  localparam int MAC_A_W     = 18;
  localparam int MAC_B_W     = HEIGHT_BITS + 1;
  localparam int PROD_W      = MAC_A_W + MAC_B_W;
  localparam int ACC_W       = PROD_W + 2;

  localparam logic signed [OUT_W-1:0] OUTSIDE_HEIGHT = 16'sd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_HEIGHT = 2'd0,
    ACT_PIXEL  = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_GAIN   = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIX,
    ST_WR,
    ST_CHK,
    ST_R0,
    ST_R1,
    ST_R2,
    ST_R3,
    ST_R4,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_load;
    logic acc_add;
  } mac_ctl_t;

  localparam logic signed [ACC_W-1:0] H_MAX = ACC_W'((64'sd1 <<< (HEIGHT_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] H_MIN = -H_MAX - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] O_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] O_MIN = -O_MAX - ACC_W'(1);

  function automatic logic signed [HEIGHT_BITS-1:0] sat_height(
      input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = (v > H_MAX) ? H_MAX : ((v < H_MIN) ? H_MIN : v);
    return r[HEIGHT_BITS-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = (v > O_MAX) ? O_MAX : ((v < O_MIN) ? O_MIN : v);
    return r[OUT_W-1:0];
  endfunction

endpackage

@@ design/hti_item_if.sv @@
// Input item channel: writes and queries
interface hti_item_if;
  import hti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_y;
  logic signed [OUT_W-1:0]  height_value;
  logic [PIX_W-1:0]         pixel_value;
  logic signed [POS_W-1:0]  query_x;
  logic signed [POS_W-1:0]  query_y;

  modport source (output valid, action, cell_x, cell_y, height_value, pixel_value,
                  query_x, query_y, input ready);
  modport sink (input valid, action, cell_x, cell_y, height_value, pixel_value,
                query_x, query_y, output ready);
endinterface

@@ design/hti_result_if.sv @@
// Result channel: interpolated height per query
interface hti_result_if;
  import hti_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  surface_height;
  logic                     inside_grid;

  modport source (output valid, surface_height, inside_grid, input ready);
  modport sink (input valid, surface_height, inside_grid, output ready);
endinterface

@@ design/hti_cfg_if.sv @@
// Configuration write channel
interface hti_cfg_if;
  import hti_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/heightfield_triangle_interpolator.sv @@
// Top level of the height-field triangle interpolator
//
//   channel  modport  word contents
//   item     sink     action, cell_x, cell_y, height_value, pixel_value, query_x, query_y
//   result   source   surface_height, inside_grid (one word per query)
//   cfg      sink     index, data (grid_width, grid_height, stretch_gain)
//
// Height write: state WR; scaled pixel write: PIX then WR; query outside the grid: CHK then OUT;
// query inside: CHK, R0 to R4 and OUT, with three reads through the single store read port and the
// one shared multiply-accumulate unit. item.ready is high only between items.
// After reset all 65536 store entries are cleared one entry a cycle, with item.ready low;
// cfg writes are always taken. A stalled result holds the sequencer before it returns idle.
module heightfield_triangle_interpolator (
  input  logic         clk,
  input  logic         rst,
  hti_item_if.sink     item,
  hti_result_if.source result,
  hti_cfg_if.sink      cfg
);
  import hti_pkg::*;

  logic [DIM_W-1:0]  grid_width;
  logic [DIM_W-1:0]  grid_height;
  logic [GAIN_W-1:0] stretch_gain;
  logic [DIM_W-1:0]  w_used, h_used;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [HEIGHT_BITS-1:0]  ram_wdata, ram_rdata;
  mac_ctl_t                mac_ctl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= '0;
      grid_height  <= '0;
      stretch_gain <= GAIN_W'(FRAC_ONE);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_WIDTH:  grid_width   <= cfg.data[DIM_W-1:0];
        CFG_HEIGHT: grid_height  <= cfg.data[DIM_W-1:0];
        CFG_GAIN:   stretch_gain <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_used = (grid_width > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : grid_width;
  assign h_used = (grid_height > DIM_W'(GRID_SIDE)) ? DIM_W'(GRID_SIDE) : grid_height;

  hti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .result    (result),
    .w_used    (w_used),
    .h_used    (h_used),
    .gain      (stretch_gain),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .mac_ctl   (mac_ctl),
    .mac_a     (mac_a),
    .mac_b     (mac_b),
    .prod      (prod),
    .acc       (acc)
  );

  hti_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (mac_b),
    .prod (prod),
    .acc  (acc)
  );

  hti_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ design/hti_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module hti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/hti_mac.sv @@
// Shared multiply-accumulate unit: registered product, then accumulate
module hti_mac (
  input  logic                               clk,
  input  hti_pkg::mac_ctl_t                  ctl,
  input  logic signed [hti_pkg::MAC_A_W-1:0] a,
  input  logic signed [hti_pkg::MAC_B_W-1:0] b,
  output logic signed [hti_pkg::PROD_W-1:0]  prod,
  output logic signed [hti_pkg::ACC_W-1:0]   acc
);
  import hti_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    if (ctl.acc_load) begin
      acc <= ACC_W'(prod);
    end else if (ctl.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

@@ design/hti_ctrl.sv @@
// Sequencer: store clearing, writes, cell lookup and three-term interpolation
module hti_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  hti_item_if.sink                              item,
  hti_result_if.source                          result,
  input  logic [hti_pkg::DIM_W-1:0]             w_used,
  input  logic [hti_pkg::DIM_W-1:0]             h_used,
  input  logic [hti_pkg::GAIN_W-1:0]            gain,
  output logic                                  ram_we,
  output logic [hti_pkg::ADDR_W-1:0]            ram_waddr,
  output logic [hti_pkg::HEIGHT_BITS-1:0]       ram_wdata,
  output logic [hti_pkg::ADDR_W-1:0]            ram_raddr,
  input  logic [hti_pkg::HEIGHT_BITS-1:0]       ram_rdata,
  output hti_pkg::mac_ctl_t                     mac_ctl,
  output logic signed [hti_pkg::MAC_A_W-1:0]    mac_a,
  output logic signed [hti_pkg::MAC_B_W-1:0]    mac_b,
  input  logic signed [hti_pkg::PROD_W-1:0]     prod,
  input  logic signed [hti_pkg::ACC_W-1:0]      acc
);
  import hti_pkg::*;

  localparam logic signed [POS_W-1:0] POS_MIN_IN = -POS_W'(FRAC_ONE - 1);
  localparam logic signed [WGT_W-1:0] WGT_ONE    = WGT_W'(FRAC_ONE);
  localparam logic signed [FRAC_W+1:0] D_MAX     = (FRAC_W + 2)'(FRAC_ONE);

  state_t state, state_next;

  // latched item
  logic [ACT_W-1:0]        act;
  logic [CELL_W-1:0]       cx;
  logic [CELL_W-1:0]       cy;
  logic signed [OUT_W-1:0] hval;
  logic [PIX_W-1:0]        pix;
  logic signed [POS_W-1:0] qx;
  logic signed [POS_W-1:0] qy;

  // per-query cell data
  logic                    in_grid;
  logic                    tri_a;
  logic [IDX_W-1:0]        cx0, cy0, cx1, cy1;
  logic signed [WGT_W-1:0] wt0, wt1, wt2;

  logic [ADDR_W-1:0]       clr_addr;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_height;
  logic                    out_inside;
  logic                    out_load;
  logic                    accept;

  // cell lookup, combinational from the latched position
  logic                    x_ok, y_ok, inside_c, tri_a_c;
  logic [CMP_W-1:0]        rx, ry;
  logic signed [FRAC_W:0]  fx, fy;
  logic signed [FRAC_W+1:0] d;
  logic signed [ACC_W-1:0] q;

  assign accept = item.valid && item.ready;

  always_comb begin
    x_ok = !qx[POS_W-1] || (qx >= POS_MIN_IN);
    y_ok = !qy[POS_W-1] || (qy >= POS_MIN_IN);
    // truncation toward zero: small negatives land in cell 0 with a negative fraction
    rx = qx[POS_W-1] ? '0 : CMP_W'(qx[POS_W-2:FRAC_W]);
    ry = qy[POS_W-1] ? '0 : CMP_W'(qy[POS_W-2:FRAC_W]);
    fx = qx[POS_W-1] ? qx[FRAC_W:0] : {1'b0, qx[FRAC_W-1:0]};
    fy = qy[POS_W-1] ? qy[FRAC_W:0] : {1'b0, qy[FRAC_W-1:0]};
    inside_c = x_ok && y_ok && ((rx + CMP_W'(1)) < CMP_W'(w_used))
               && ((ry + CMP_W'(1)) < CMP_W'(h_used));
    d = (FRAC_W + 2)'(fy) - (FRAC_W + 2)'(fx);
    tri_a_c = !d[FRAC_W+1] && (d <= D_MAX);
    q = acc + ACC_W'(FRAC_ONE / 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = {IDX_W'(cx), IDX_W'(cy)};
    ram_wdata  = '0;
    ram_raddr  = {cx0, cy0};
    mac_ctl    = '0;
    mac_a      = MAC_A_W'(wt0);
    mac_b      = MAC_B_W'($signed(ram_rdata));
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.action)
            ACT_HEIGHT: state_next = ST_WR;
            ACT_PIXEL:  state_next = ST_PIX;
            ACT_QUERY:  state_next = ST_CHK;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PIX: begin
        mac_ctl.mul_en = 1'b1;
        mac_a = MAC_A_W'($signed({1'b0, gain}));
        mac_b = MAC_B_W'($signed({1'b0, pix}));
        state_next = ST_WR;
      end
      ST_WR: begin
        ram_we = (DIM_W'(cx) < w_used) && (DIM_W'(cy) < h_used);
        if (act == ACT_PIXEL) begin
          ram_wdata = sat_height(ACC_W'(prod >>> FRAC_W));
        end else begin
          ram_wdata = sat_height(ACC_W'(hval));
        end
        state_next = ST_IDLE;
      end
      ST_CHK: begin
        state_next = inside_c ? ST_R0 : ST_OUT;
      end
      ST_R0: begin
        ram_raddr  = {cx0, cy0};
        state_next = ST_R1;
      end
      ST_R1: begin
        ram_raddr      = {cx1, cy1};
        mac_ctl.mul_en = 1'b1;
        mac_a          = MAC_A_W'(wt0);
        state_next     = ST_R2;
      end
      ST_R2: begin
        ram_raddr        = tri_a ? {cx0, cy1} : {cx1, cy0};
        mac_ctl.mul_en   = 1'b1;
        mac_ctl.acc_load = 1'b1;
        mac_a            = MAC_A_W'(wt1);
        state_next       = ST_R3;
      end
      ST_R3: begin
        mac_ctl.mul_en  = 1'b1;
        mac_ctl.acc_add = 1'b1;
        mac_a           = MAC_A_W'(wt2);
        state_next      = ST_R4;
      end
      ST_R4: begin
        mac_ctl.acc_add = 1'b1;
        state_next      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= item.action;
      cx   <= item.cell_x;
      cy   <= item.cell_y;
      hval <= item.height_value;
      pix  <= item.pixel_value;
      qx   <= item.query_x;
      qy   <= item.query_y;
    end
    if (state == ST_CHK) begin
      in_grid <= inside_c;
      tri_a   <= tri_a_c;
      cx0     <= rx[IDX_W-1:0];
      cy0     <= ry[IDX_W-1:0];
      cx1     <= rx[IDX_W-1:0] + IDX_W'(1);
      cy1     <= ry[IDX_W-1:0] + IDX_W'(1);
      if (tri_a_c) begin
        wt0 <= WGT_ONE - WGT_W'(fy);
        wt1 <= WGT_W'(fx);
        wt2 <= WGT_W'(d);
      end else begin
        wt0 <= WGT_ONE - WGT_W'(fx);
        wt1 <= WGT_W'(fy);
        wt2 <= -WGT_W'(d);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_inside <= in_grid;
      out_height <= in_grid ? sat_out(q >>> FRAC_W) : OUTSIDE_HEIGHT;
    end
  end

  assign result.valid          = out_valid;
  assign result.surface_height = out_height;
  assign result.inside_grid    = out_inside;

endmodule

@@ design/hti_checker.sv @@
// Port-level assertions for the interpolator, bound to the top level
`include "assert_macros.svh"

module hti_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [hti_pkg::ACT_W-1:0]      in_action,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [hti_pkg::OUT_W-1:0] surface_height,
  input logic                           inside_grid
);
  import hti_pkg::*;

  logic work_taken;

  // a no-op word leaves the sequencer idle
  assign work_taken = in_valid && in_ready && (in_action != ACT_NOP);

  // store clearing starts right after reset
  `HTI_ASSERT_NXT(a_clear_after_reset, clk, 1'b0, rst, !in_ready, "ready during clearing pass")

  // every accepted working word takes the sequencer out of idle, so ready is low in the cycle after
  `HTI_ASSERT_NXT(a_busy_after_accept, clk, rst, work_taken, !in_ready, "ready right after accept")

  // outside queries carry the fixed height
  `HTI_ASSERT_IMP(a_outside_value, clk, rst, out_valid && !inside_grid, surface_height == OUTSIDE_HEIGHT, "outside height wrong")

  // a stalled result word holds
  `HTI_ASSERT_NXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(surface_height) && $stable(inside_grid), "stalled result changed")

endmodule

bind heightfield_triangle_interpolator hti_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .in_action      (item.action),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .surface_height (result.surface_height),
  .inside_grid    (result.inside_grid)
);
